// ===== hw/rtl/dual_sensor_intrusion_alarm_macros.svh =====
// Assertion macros shared by the intrusion alarm RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DUAL_SENSOR_INTRUSION_ALARM_MACROS_SVH
`define DUAL_SENSOR_INTRUSION_ALARM_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DSIA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dsia_pkg.sv =====
// Shared types and constants of the intrusion alarm.
// No dependencies; used by dsia_in_if and every RTL module.
package dsia_pkg;

    localparam int DEF_WINDOW_SAMPLES = 50;
    localparam int DEF_SAMPLE_BITS    = 10;

    localparam int THR_W      = 10;
    localparam int HOLD_W     = 16;
    localparam int BLINK_W    = 16;
    localparam int DEB_W      = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CMP_W      = 17;

    localparam logic [THR_W-1:0]   RST_THRESHOLD = THR_W'(300);
    localparam logic [HOLD_W-1:0]  RST_HOLD      = HOLD_W'(1500);
    localparam logic [BLINK_W-1:0] RST_BLINK     = BLINK_W'(250);
    localparam logic [DEB_W-1:0]   RST_DEBOUNCE  = DEB_W'(50);
    localparam logic [HOLD_W-1:0]  ELAPSED_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_HOLD      = 2'd1,
        CFG_BLINK     = 2'd2,
        CFG_DEBOUNCE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ALARM_NORMAL   = 2'd0,
        ALARM_INFRARED = 2'd1,
        ALARM_ACOUSTIC = 2'd2
    } t_alarm;

    typedef enum logic [1:0] {
        TONE_SILENT   = 2'd0,
        TONE_INFRARED = 2'd1,
        TONE_ACOUSTIC = 2'd2
    } t_tone;

    typedef struct packed {
        logic [THR_W-1:0]   threshold;
        logic [HOLD_W-1:0]  hold_ms;
        logic [BLINK_W-1:0] blink_half_ms;
        logic [DEB_W-1:0]   debounce_time;
    } t_cfg;

endpackage

// ===== hw/rtl/dsia_in_if.sv =====
// Input channel of the intrusion alarm: valid/ready plus one sensor item.
// Depends on dsia_pkg for the default sample width.
interface dsia_in_if #(
    parameter int SAMPLE_BITS = dsia_pkg::DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] mic_sample;
    logic                   infrared_level;
    logic                   button_level;
    logic                   ms_tick;

    modport source (output valid, mic_sample, infrared_level, button_level, ms_tick,
                    input ready);
    modport sink   (input valid, mic_sample, infrared_level, button_level, ms_tick,
                    output ready);
endinterface

// ===== hw/rtl/dsia_out_if.sv =====
// Output channel of the intrusion alarm: valid/ready plus one result item.
// No dependencies.
interface dsia_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] alarm_state;
    logic       led_red;
    logic       led_green;
    logic       led_blue;
    logic [1:0] tone_select;
    logic       sound_enabled;

    modport source (output valid, alarm_state, led_red, led_green, led_blue, tone_select,
                    sound_enabled, input ready);
    modport sink   (input valid, alarm_state, led_red, led_green, led_blue, tone_select,
                    sound_enabled, output ready);
endinterface

// ===== hw/rtl/dsia_button.sv =====
// Button debouncer and sound-alarm enable toggle.
// Depends on dsia_pkg and the assertion macros header.
`include "dual_sensor_intrusion_alarm_macros.svh"

module dsia_button (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic                     i_level,
    input  logic                     i_tick,
    input  logic [dsia_pkg::DEB_W-1:0] i_debounce_time,
    output logic                     o_enable_next
);
    logic                       r_enable, n_enable;
    logic                       r_prev;
    logic                       r_busy, n_busy;
    logic [dsia_pkg::DEB_W-1:0] r_cnt, n_cnt;
    logic [dsia_pkg::DEB_W-1:0] w_cnt_inc;

    assign w_cnt_inc = r_cnt + dsia_pkg::DEB_W'(1);

    always_comb begin
        n_enable = r_enable;
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        if (r_busy) begin
            if (i_level) begin
                n_busy = 1'b0;                // released early: drop the press
            end else if (i_tick) begin
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= i_debounce_time) begin
                    n_enable = ~r_enable;
                    n_busy   = 1'b0;
                end
            end
        end else if (r_prev && !i_level) begin
            if (i_debounce_time == '0) begin
                n_enable = ~r_enable;
            end else begin
                n_busy = 1'b1;
                n_cnt  = '0;
            end
        end
    end

    assign o_enable_next = n_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_prev   <= 1'b1;
            r_busy   <= 1'b0;
            r_cnt    <= '0;
        end else if (i_step) begin
            r_enable <= n_enable;
            r_prev   <= i_level;
            r_busy   <= n_busy;
            r_cnt    <= n_cnt;
        end
    end

    `DSIA_ASSERT_NEXT(a_release_ends_debounce, i_clk, i_rst_n,
        i_step && r_busy && i_level, !r_busy, "debounce kept running after release")

endmodule

// ===== hw/rtl/dsia_window.sv =====
// Peak-to-peak tracker over a window of samples; flags a loud window.
// Depends on dsia_pkg and the assertion macros header.
`include "dual_sensor_intrusion_alarm_macros.svh"

module dsia_window #(
    parameter int WINDOW_SAMPLES = dsia_pkg::DEF_WINDOW_SAMPLES,
    parameter int SAMPLE_BITS    = dsia_pkg::DEF_SAMPLE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [SAMPLE_BITS-1:0]     i_sample,
    input  logic                       i_enable,
    input  logic [dsia_pkg::THR_W-1:0] i_threshold,
    output logic                       o_trigger
);
    localparam int CntW = $clog2(WINDOW_SAMPLES);
    localparam logic [CntW-1:0] CntLast = CntW'(WINDOW_SAMPLES - 1);

    logic [SAMPLE_BITS-1:0] r_min, n_min;
    logic [SAMPLE_BITS-1:0] r_max, n_max;
    logic [CntW-1:0]        r_cnt;
    logic [SAMPLE_BITS-1:0] w_swing;
    logic                   w_close;
    logic                   w_loud;

    assign n_min   = (i_sample < r_min) ? i_sample : r_min;
    assign n_max   = (i_sample > r_max) ? i_sample : r_max;
    assign w_close = (r_cnt == CntLast);
    assign w_swing = (n_max >= n_min) ? (n_max - n_min) : '0;
    assign w_loud  = {{(dsia_pkg::CMP_W - SAMPLE_BITS){1'b0}}, w_swing}
                     >= {{(dsia_pkg::CMP_W - dsia_pkg::THR_W){1'b0}}, i_threshold};
    assign o_trigger = i_step && w_close && i_enable && w_loud;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '1;
            r_max <= '0;
            r_cnt <= '0;
        end else if (i_step) begin
            if (w_close) begin
                r_min <= '1;
                r_max <= '0;
                r_cnt <= '0;
            end else begin
                r_min <= n_min;
                r_max <= n_max;
                r_cnt <= r_cnt + CntW'(1);
            end
        end
    end

    `DSIA_ASSERT_IMPLY(a_count_in_window, i_clk, i_rst_n,
        1'b1, r_cnt <= CntLast, "window count ran past the window length")

endmodule

// ===== hw/rtl/dsia_timers.sv =====
// Millisecond timers: saturating time since last loud window, and blink phase.
// Depends on dsia_pkg and the assertion macros header.
`include "dual_sensor_intrusion_alarm_macros.svh"

module dsia_timers (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic                         i_tick,
    input  logic                         i_trigger,
    input  logic [dsia_pkg::BLINK_W-1:0] i_blink_half_ms,
    output logic [dsia_pkg::HOLD_W-1:0]  o_elapsed_next,
    output logic                         o_phase_next
);
    logic [dsia_pkg::HOLD_W-1:0]  r_elapsed, n_elapsed;
    logic [dsia_pkg::BLINK_W-1:0] r_blink, n_blink;
    logic                         r_phase, n_phase;
    logic [dsia_pkg::BLINK_W:0]   w_blink_inc;

    assign w_blink_inc = {1'b0, r_blink} + (dsia_pkg::BLINK_W + 1)'(1);

    always_comb begin
        n_elapsed = r_elapsed;
        n_blink   = r_blink;
        n_phase   = r_phase;
        if (i_tick) begin
            if (r_elapsed != dsia_pkg::ELAPSED_MAX) begin
                n_elapsed = r_elapsed + dsia_pkg::HOLD_W'(1);
            end
            if (w_blink_inc >= {1'b0, i_blink_half_ms}) begin
                n_blink = '0;
                n_phase = ~r_phase;
            end else begin
                n_blink = w_blink_inc[dsia_pkg::BLINK_W-1:0];
            end
        end
        if (i_trigger) begin
            n_elapsed = '0;                   // loud window restarts the hold
        end
    end

    assign o_elapsed_next = n_elapsed;
    assign o_phase_next   = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= dsia_pkg::ELAPSED_MAX;
            r_blink   <= '0;
            r_phase   <= 1'b1;
        end else if (i_step) begin
            r_elapsed <= n_elapsed;
            r_blink   <= n_blink;
            r_phase   <= n_phase;
        end
    end

    `DSIA_ASSERT_NEXT(a_trigger_clears_elapsed, i_clk, i_rst_n,
        i_step && i_trigger, r_elapsed == '0, "loud window did not restart hold timer")

endmodule

// ===== hw/rtl/dual_sensor_intrusion_alarm.sv =====
// Top level of the dual-sensor intrusion alarm.
// Depends on dsia_pkg, dsia_in_if, dsia_out_if, dsia_button, dsia_window, dsia_timers.
//
// Usage:
//   i_in  : sensor transactions (microphone sample, infrared and button pin
//           levels, millisecond tick). One transaction per sample period.
//   o_out : one result transaction per input transaction: alarm state, lamp
//           channels, tone select and the current sound-alarm enable.
//   i_cfg_*: register writes (threshold, hold, blink half period, debounce),
//           one per cycle with i_cfg_we high; write only while the block idles.
// Path: an accepted transaction goes into the input register, is processed,
//   then is captured in the result register that drives o_out.
// Throughput: one transaction per cycle while o_out is not stalled; an input
//   register and a result register each hold one transaction, and all sensor
//   state advances as a transaction moves from the one to the other.
// Stall: while o_out.ready is low the result holds; one more transaction is
//   taken into the input register, then i_in.ready drops until o_out drains.
// Reset (synchronous, active low): pipeline empties, registers take their
//   defaults, sound alarm enabled, hold timer saturated so no acoustic alarm
//   shows at start-up, blink phase starts with the lamp on.
`include "dual_sensor_intrusion_alarm_macros.svh"

module dual_sensor_intrusion_alarm #(
    parameter int WINDOW_SAMPLES = dsia_pkg::DEF_WINDOW_SAMPLES,
    parameter int SAMPLE_BITS    = dsia_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dsia_in_if.sink                         i_in,
    dsia_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [dsia_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dsia_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] mic_sample;
        logic                   infrared_level;
        logic                   button_level;
        logic                   ms_tick;
    } t_item;

    typedef struct packed {
        dsia_pkg::t_alarm alarm_state;
        logic             led_red;
        logic             led_green;
        logic             led_blue;
        dsia_pkg::t_tone  tone_select;
        logic             sound_enabled;
    } t_result;

    dsia_pkg::t_cfg r_cfg;

    logic    r_s1_valid;
    t_item   r_s1;
    logic    r_out_valid;
    t_result r_out, n_out;

    logic                        w_adv;
    logic                        w_step;
    logic                        w_enable_next;
    logic                        w_trigger;
    logic [dsia_pkg::HOLD_W-1:0] w_elapsed_next;
    logic                        w_phase_next;

    // Configuration registers: one write per cycle, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= dsia_pkg::RST_THRESHOLD;
            r_cfg.hold_ms       <= dsia_pkg::RST_HOLD;
            r_cfg.blink_half_ms <= dsia_pkg::RST_BLINK;
            r_cfg.debounce_time <= dsia_pkg::RST_DEBOUNCE;
        end else if (i_cfg_we) begin
            unique case (dsia_pkg::t_cfg_idx'(i_cfg_idx))
                dsia_pkg::CFG_THRESHOLD: begin
                    r_cfg.threshold <= i_cfg_data[dsia_pkg::THR_W-1:0];
                end
                dsia_pkg::CFG_HOLD: begin
                    r_cfg.hold_ms <= i_cfg_data[dsia_pkg::HOLD_W-1:0];
                end
                dsia_pkg::CFG_BLINK: begin
                    r_cfg.blink_half_ms <= i_cfg_data[dsia_pkg::BLINK_W-1:0];
                end
                dsia_pkg::CFG_DEBOUNCE: begin
                    r_cfg.debounce_time <= i_cfg_data[dsia_pkg::DEB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake: advance the input stage whenever the result register frees up.
    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || w_adv;
    assign w_step     = r_s1_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers: capture the input, hold the result while stalled.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1.mic_sample     <= i_in.mic_sample;
            r_s1.infrared_level <= i_in.infrared_level;
            r_s1.button_level   <= i_in.button_level;
            r_s1.ms_tick        <= i_in.ms_tick;
        end
        if (w_step) begin
            r_out <= n_out;
        end
    end

    // Button first, then the window sees the updated enable.
    dsia_button u_button (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_level         (r_s1.button_level),
        .i_tick          (r_s1.ms_tick),
        .i_debounce_time (r_cfg.debounce_time),
        .o_enable_next   (w_enable_next)
    );

    dsia_window #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_sample    (r_s1.mic_sample),
        .i_enable    (w_enable_next),
        .i_threshold (r_cfg.threshold),
        .o_trigger   (w_trigger)
    );

    // Tick advances the timers; a loud window then overrides the elapsed count.
    dsia_timers u_timers (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_tick          (r_s1.ms_tick),
        .i_trigger       (w_trigger),
        .i_blink_half_ms (r_cfg.blink_half_ms),
        .o_elapsed_next  (w_elapsed_next),
        .o_phase_next    (w_phase_next)
    );

    // Priority: infrared over acoustic over normal.
    always_comb begin
        n_out               = '0;
        n_out.sound_enabled = w_enable_next;
        if (!r_s1.infrared_level) begin
            n_out.alarm_state = dsia_pkg::ALARM_INFRARED;
            n_out.led_red     = w_phase_next;
            n_out.tone_select = w_phase_next ? dsia_pkg::TONE_INFRARED
                                             : dsia_pkg::TONE_SILENT;
        end else if (w_elapsed_next < r_cfg.hold_ms) begin
            n_out.alarm_state = dsia_pkg::ALARM_ACOUSTIC;
            n_out.led_red     = w_phase_next;
            n_out.led_blue    = w_phase_next;
            n_out.tone_select = w_phase_next ? dsia_pkg::TONE_ACOUSTIC
                                             : dsia_pkg::TONE_SILENT;
        end else begin
            n_out.alarm_state = dsia_pkg::ALARM_NORMAL;
            n_out.led_green   = 1'b1;
            n_out.tone_select = dsia_pkg::TONE_SILENT;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.alarm_state   = r_out.alarm_state;
    assign o_out.led_red       = r_out.led_red;
    assign o_out.led_green     = r_out.led_green;
    assign o_out.led_blue      = r_out.led_blue;
    assign o_out.tone_select   = r_out.tone_select;
    assign o_out.sound_enabled = r_out.sound_enabled;

    `DSIA_ASSERT_NEXT(a_step_fills_result, i_clk, i_rst_n,
        w_step, r_out_valid, "processed transaction did not reach the result register")
    `DSIA_ASSERT_IMPLY(a_normal_is_steady_green, i_clk, i_rst_n,
        r_out_valid && r_out.alarm_state == dsia_pkg::ALARM_NORMAL,
        r_out.led_green && !r_out.led_red && !r_out.led_blue
            && r_out.tone_select == dsia_pkg::TONE_SILENT,
        "normal state must show steady green and no tone")

endmodule
